// ===== hdl/rle_escape_codec_macros.svh =====
// Assertion macros shared by the run-length codec RTL.
`ifndef RLE_ESCAPE_CODEC_MACROS_SVH
`define RLE_ESCAPE_CODEC_MACROS_SVH

`ifndef ASSERT_OFF

// cond must never hold outside reset
`define RLEC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante implies cons in the same cycle, outside reset
`define RLEC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else \
    $error("implication failed");

// ante implies cons in the next cycle, checked during reset too
`define RLEC_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`else

`define RLEC_ASSERT_NEVER(label, clk, rst, cond, msg)
`define RLEC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RLEC_ASSERT_NEXT(label, clk, ante, cons, msg)

`endif

`endif

// ===== hdl/rlec_pkg.sv =====
// Shared types and constants of the run-length codec.
package rlec_pkg;

  localparam int MAX_RUN_DEF     = 9;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] ESC_RESET  = 8'd82;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_ESC  = 1'b1;

  // codec_mode values
  localparam logic MODE_COMPRESS   = 1'b0;
  localparam logic MODE_DECOMPRESS = 1'b1;

  // output segment kinds
  typedef enum logic [1:0] {
    SEG_NONE = 2'd0,  // nothing
    SEG_LIT  = 2'd1,  // one plain byte
    SEG_CODE = 2'd2,  // escape, byte, digit
    SEG_REP  = 2'd3   // byte repeated count times
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t   kind;
    logic [7:0]  data;
    logic [3:0]  count;
  } seg_t;

  // one queued command: up to two segments, first one always used
  typedef struct packed {
    seg_t        a;
    seg_t        b;
    logic [7:0]  esc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // decoder phases; the unused code is handled as plain
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_RUN   = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

endpackage

// ===== hdl/rlec_front.sv =====
// Front end: takes input bytes, updates codec state, issues output commands.
module rlec_front #(
  parameter int MAX_RUN = rlec_pkg::MAX_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,     // [7:0] in_byte
  input  logic              s_tlast,     // end_of_stream
  input  logic              codec_mode,
  input  logic [7:0]        escape_char,
  input  rlec_pkg::q_status_t q_status,
  output logic              push,
  output rlec_pkg::cmd_t    push_cmd
);
  import rlec_pkg::*;

  localparam logic [3:0] RUN_LIMIT = 4'(MAX_RUN);

  logic [7:0] run_byte;
  logic [3:0] run_length;
  phase_t     decode_phase;
  logic [7:0] held_byte;

  logic [7:0] run_byte_next;
  logic [3:0] run_length_next;
  phase_t     decode_phase_next;
  logic [7:0] held_byte_next;

  logic       accept;
  seg_t       seg_first;
  seg_t       seg_second;
  logic [3:0] digit_val;
  logic       extend;

  // code a finished run
  function automatic seg_t flush_seg(input logic [3:0] len, input logic [7:0] value,
                                     input logic [7:0] esc);
    seg_t s;
    s.kind  = SEG_NONE;
    s.data  = value;
    s.count = len;
    if (len != 4'd0) begin
      if (len > 4'd1 || value == esc) begin
        s.kind = SEG_CODE;
      end else begin
        s.kind = SEG_LIT;
      end
    end
    return s;
  endfunction

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  assign extend    = run_length != 4'd0 && s_tdata == run_byte && run_length < RUN_LIMIT;
  assign digit_val = 4'(s_tdata - DIGIT_ZERO);

  // next state and segments for the current byte
  always_comb begin
    run_byte_next     = run_byte;
    run_length_next   = run_length;
    decode_phase_next = decode_phase;
    held_byte_next    = held_byte;
    seg_first         = '{kind: SEG_NONE, data: s_tdata, count: 4'd1};
    seg_second        = '{kind: SEG_NONE, data: s_tdata, count: 4'd1};

    if (codec_mode == MODE_COMPRESS) begin
      if (extend) begin
        run_length_next = run_length + 4'd1;
      end else begin
        seg_first       = flush_seg(run_length, run_byte, escape_char);
        run_byte_next   = s_tdata;
        run_length_next = 4'd1;
      end
      if (s_tlast) begin
        seg_second      = flush_seg(run_length_next, run_byte_next, escape_char);
        run_length_next = 4'd0;
      end
    end else begin
      unique case (decode_phase)
        PH_RUN: begin
          held_byte_next    = s_tdata;
          decode_phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          if (s_tdata >= DIGIT_ZERO && s_tdata <= DIGIT_NINE && digit_val != 4'd0) begin
            seg_first = '{kind: SEG_REP, data: held_byte, count: digit_val};
          end
          decode_phase_next = PH_PLAIN;
        end
        default: begin
          if (s_tdata == escape_char) begin
            decode_phase_next = PH_RUN;
          end else begin
            seg_first = '{kind: SEG_LIT, data: s_tdata, count: 4'd1};
          end
        end
      endcase
      if (s_tlast) begin
        decode_phase_next = PH_PLAIN;
      end
    end

    // keep the first segment filled
    if (seg_first.kind == SEG_NONE) begin
      push_cmd.a = seg_second;
      push_cmd.b = '{kind: SEG_NONE, data: s_tdata, count: 4'd1};
    end else begin
      push_cmd.a = seg_first;
      push_cmd.b = seg_second;
    end
    push_cmd.esc = escape_char;
  end

  assign push = accept && push_cmd.a.kind != SEG_NONE;

  // codec state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_byte     <= 8'd0;
      run_length   <= 4'd0;
      decode_phase <= PH_PLAIN;
      held_byte    <= 8'd0;
    end else if (accept) begin
      run_byte     <= run_byte_next;
      run_length   <= run_length_next;
      decode_phase <= decode_phase_next;
      held_byte    <= held_byte_next;
    end
  end

endmodule

// ===== hdl/rlec_queue.sv =====
// Short command queue between front and back end.
module rlec_queue #(
  parameter int DEPTH = rlec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rlec_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output rlec_pkg::cmd_t      head,
  output rlec_pkg::q_status_t status
);
  import rlec_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign status.full  = fill == CW'(DEPTH);
  assign status.empty = fill == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rlec_back.sv =====
// Back end: expands queued commands to bytes, one per ready cycle.
module rlec_back (
  input  logic                clk,
  input  logic                rst,
  input  rlec_pkg::cmd_t      head,
  input  rlec_pkg::q_status_t q_status,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] out_byte
  output logic                m_tlast    // last_of_item
);
  import rlec_pkg::*;

  logic       sel;      // 0 first segment, 1 second segment
  logic [3:0] pos;      // byte position inside the segment

  seg_t       seg;
  logic [3:0] seg_len;
  logic [7:0] cur_byte;
  logic       seg_last;
  logic       cmd_last;
  logic       load;

  // current byte of the head command
  always_comb begin
    seg = sel ? head.b : head.a;
    unique case (seg.kind)
      SEG_CODE: begin
        seg_len = 4'd3;
        if (pos == 4'd0) begin
          cur_byte = head.esc;
        end else if (pos == 4'd1) begin
          cur_byte = seg.data;
        end else begin
          cur_byte = DIGIT_ZERO + {4'd0, seg.count};
        end
      end
      SEG_REP: begin
        seg_len  = seg.count;
        cur_byte = seg.data;
      end
      default: begin
        seg_len  = 4'd1;
        cur_byte = seg.data;
      end
    endcase
    seg_last = pos == seg_len - 4'd1;
    cmd_last = seg_last && (sel || head.b.kind == SEG_NONE);
  end

  assign load = !q_status.empty && (!m_tvalid || m_tready);
  assign pop  = load && cmd_last;

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur_byte;
      m_tlast <= cmd_last;
    end
  end

  // position counters and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 1'b0;
      pos      <= 4'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        if (seg_last) begin
          pos <= 4'd0;
          sel <= !cmd_last;
        end else begin
          pos <= pos + 4'd1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/rle_escape_codec.sv =====
// Top level of the escape-byte run-length codec.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata[7:0] in_byte, tlast eos
//  m_*      | out       | m_tvalid/m_tready  | tdata[7:0] out_byte, tlast last
//  cfg_*    | in        | cfg_we             | addr 0 codec_mode, 1 escape_char
//
// One input byte is taken per cycle while the command queue has room; the
// front end classifies it and updates the codec state in that cycle.
// The back end sends one output byte per cycle while m_tready allows; a coded
// run gives 3 bytes, an expansion up to 9, an end-of-stream flush up to 6. The
// back end's expansion counter sets the output rate; QUEUE_DEPTH commands
// absorb it. Synchronous reset spares only queue storage and m_tdata/m_tlast.
`include "rle_escape_codec_macros.svh"

module rle_escape_codec #(
  parameter int MAX_RUN     = rlec_pkg::MAX_RUN_DEF,
  parameter int QUEUE_DEPTH = rlec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_of_item
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_data
);
  import rlec_pkg::*;

  logic       codec_mode;
  logic [7:0] escape_char;

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  q_status_t  q_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode  <= MODE_COMPRESS;
      escape_char <= ESC_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MODE) begin
        codec_mode <= cfg_data[0];
      end else begin
        escape_char <= cfg_data;
      end
    end
  end

  rlec_front #(.MAX_RUN(MAX_RUN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .codec_mode  (codec_mode),
    .escape_char (escape_char),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  rlec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  rlec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // checks
  `RLEC_ASSERT_NEXT(a_reset_idle, clk, rst, !m_tvalid && q_status.empty, "not idle after reset")
  `RLEC_ASSERT_NEVER(a_pop_empty, clk, rst, pop && q_status.empty, "pop from empty queue")
  `RLEC_ASSERT_IMPLIES(a_push_filled, clk, rst, push, push_cmd.a.kind != SEG_NONE)

endmodule

// ===== sim/rle_stream_checker.sv =====
// Stream checker for the run-length codec: predicts output bytes and compares them.
module rle_stream_checker #(
  parameter int MAX_RUN = rlec_pkg::MAX_RUN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         outstanding,
  output int         bytes_in,
  output int         bytes_out
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlec_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_rec_t;

  // expected output bytes, oldest first
  out_rec_t   expected_bytes[$];
  // bytes produced by the request being predicted
  logic [7:0] step_bytes[$];

  // shadow registers and codec state
  logic       mode;
  logic [7:0] esc;
  logic [7:0] run_byte;
  logic [3:0] run_len;
  phase_t     dec_phase;
  logic [7:0] held_byte;

  function automatic void emit(logic [7:0] b);
    step_bytes.push_back(b);
  endfunction

  // close the pending run: coded triple, or the bare byte
  function automatic void flush_run();
    if (run_len == 4'd0) return;
    if (run_len > 4'd1 || run_byte == esc) begin
      emit(esc);
      emit(run_byte);
      emit(DIGIT_ZERO + 8'(run_len));
    end else begin
      emit(run_byte);
    end
    run_len = 4'd0;
  endfunction

  function automatic void compress_byte(logic [7:0] b, logic eos);
    if (run_len != 4'd0 && b == run_byte && int'(run_len) < MAX_RUN) begin
      run_len = run_len + 4'd1;
    end else begin
      flush_run();
      run_byte = b;
      run_len  = 4'd1;
    end
    if (eos) flush_run();
  endfunction

  function automatic void expand_byte(logic [7:0] b, logic eos);
    case (dec_phase)
      PH_RUN: begin
        held_byte = b;
        dec_phase = PH_COUNT;
      end
      PH_COUNT: begin
        // count digits outside '0'..'9' give nothing
        if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
          for (int i = 0; i < int'(b - DIGIT_ZERO); i++) emit(held_byte);
        dec_phase = PH_PLAIN;
      end
      default: begin
        if (b == esc) dec_phase = PH_RUN;
        else emit(b);
      end
    endcase
    // a sequence cut off at end of stream is dropped
    if (eos) dec_phase = PH_PLAIN;
  endfunction

  function automatic void predict_codec_step(logic [7:0] b, logic eos);
    step_bytes.delete();
    if (mode == MODE_COMPRESS) compress_byte(b, eos);
    else expand_byte(b, eos);
    foreach (step_bytes[i])
      expected_bytes.push_back('{step_bytes[i], i == step_bytes.size() - 1});
  endfunction

  function automatic void report(string what, logic [7:0] wd, logic wl,
                                 logic [7:0] ad, logic al);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, wd, wl, ad, al);
  endfunction

  function automatic void check_result(logic [7:0] d, logic l);
    out_rec_t want;
    bytes_out++;
    if (expected_bytes.size() == 0) begin
      report("unexpected output byte", 8'h00, 1'b0, d, l);
      return;
    end
    want = expected_bytes.pop_front();
    if (want.data !== d) report("out_byte mismatch", want.data, want.last, d, l);
    else if (want.last !== l) report("last_of_item mismatch", want.data, want.last, d, l);
  endfunction

  // compare before predicting, so a byte never matches its own request
  always @(posedge clk) begin
    if (rst) begin
      mode      = MODE_COMPRESS;
      esc       = ESC_RESET;
      run_byte  = 8'h00;
      run_len   = 4'd0;
      dec_phase = PH_PLAIN;
      held_byte = 8'h00;
      expected_bytes.delete();
      mismatches = 0;
      bytes_in   = 0;
      bytes_out  = 0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
      if (cfg_we) begin
        if (cfg_addr == REG_MODE) mode = cfg_data[0];
        else esc = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        bytes_in++;
        predict_codec_step(s_tdata, s_tlast);
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the run-length codec: stimulus, handshake pacing and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlec_pkg::*;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 32;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_we;
  logic       cfg_addr;
  logic [7:0] cfg_data;

  int mismatches;
  int outstanding;
  int bytes_in;
  int bytes_out;

  bit         idle_on  = 1'b1;
  bit         hold_off = 1'b0;
  logic [7:0] cur_esc  = ESC_RESET;
  int         n_settings = 0;

  rle_escape_codec dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  rle_stream_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .bytes_in    (bytes_in),
    .bytes_out   (bytes_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Timeout with %0d output bytes still expected", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    int hold_left;
    stall     = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_left = HOLD_CYCLES;
        hold_off  = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        stall    = pick_gap();
        m_tready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // one input request; returns at the falling edge after acceptance
  task automatic send(input logic [7:0] b, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = b;
    s_tlast  = eos;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected byte
  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] val);
    cfg_addr = addr;
    cfg_data = val;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // set both registers; the mode write carries random upper bits
  task automatic configure(input logic mode, input logic [7:0] esc);
    write_reg(REG_MODE, {7'($urandom_range(0, 127)), mode});
    write_reg(REG_ESC, esc);
    cur_esc = esc;
    n_settings++;
  endtask

  // runs of one byte, some past the maximum, some ending the stream
  task automatic rand_compress(input int n);
    int         sent;
    int         len;
    int         r;
    logic [7:0] b;
    bit         eos_end;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 9);
      if (r < 3) b = cur_esc;
      else if (r < 6) b = 8'($urandom_range(0, 3));
      else b = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 50) len = $urandom_range(1, 3);
      else if (r < 85) len = $urandom_range(4, 9);
      else len = $urandom_range(10, 19);
      eos_end = ($urandom_range(0, 6) == 0);
      for (int i = 0; i < len; i++) send(b, eos_end && i == len - 1);
      sent += len;
    end
  endtask

  // mostly escape sequences, then plain bytes, then broken sequences
  task automatic rand_expand(input int n);
    int         sent;
    int         r;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        send(cur_esc, 1'b0);
        send(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 99) < 85) b = DIGIT_ZERO + 8'($urandom_range(0, 9));
        else b = 8'($urandom_range(0, 255));
        send(b, $urandom_range(0, 7) == 0);
        sent += 3;
      end else if (r < 8) begin
        b = 8'($urandom_range(0, 255));
        if (b == cur_esc) b = b ^ 8'h01;
        send(b, $urandom_range(0, 9) == 0);
        sent++;
      end else begin
        // sequence cut off by end of stream
        if ($urandom_range(0, 1) == 1) begin
          send(cur_esc, 1'b1);
          sent++;
        end else begin
          send(cur_esc, 1'b0);
          send(8'($urandom_range(0, 255)), 1'b1);
          sent += 2;
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic       modes[8];
    logic [7:0] escs[8];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = REG_MODE;
    cfg_data = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // compress at reset settings: extremes, lone escape, overlong run, flush of two runs
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(ESC_RESET, 1'b0);
    send(8'h41, 1'b0);
    send(8'h41, 1'b0);
    for (int i = 0; i < 11; i++) send(8'hAA, 1'b0);
    send(ESC_RESET, 1'b1);
    drain();

    // decompress: plain, nine copies, zero count, bad count, cut-off sequence
    configure(MODE_DECOMPRESS, ESC_RESET);
    send(8'h41, 1'b0);
    send(ESC_RESET, 1'b0);
    send(8'h41, 1'b0);
    send(DIGIT_NINE, 1'b0);
    send(ESC_RESET, 1'b0);
    send(8'h42, 1'b0);
    send(DIGIT_ZERO, 1'b0);
    send(ESC_RESET, 1'b0);
    send(8'h43, 1'b0);
    send(DIGIT_NINE + 8'd1, 1'b0);
    send(ESC_RESET, 1'b0);
    send(8'h44, 1'b1);
    drain();

    // random phases across both modes and escape extremes
    modes = '{MODE_COMPRESS, MODE_DECOMPRESS, MODE_COMPRESS, MODE_DECOMPRESS,
              MODE_COMPRESS, MODE_DECOMPRESS, MODE_COMPRESS, MODE_DECOMPRESS};
    escs  = '{ESC_RESET, ESC_RESET, 8'h00, 8'h00, 8'hFF, 8'hFF,
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    for (int p = 0; p < 8; p++) begin
      configure(modes[p], escs[p]);
      idle_on = (p != 3);
      // long output hold while input keeps coming
      if (p == 1) hold_off = 1'b1;
      if (modes[p] == MODE_COMPRESS) rand_compress(PHASE_ITEMS);
      else rand_expand(PHASE_ITEMS);
      drain();
    end

    $display("Run covered %0d input bytes and %0d output bytes over %0d register settings,",
             bytes_in, bytes_out, n_settings);
    $display("both modes, escape values 0x00, 0xFF and others, long output hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d output bytes missing", mismatches, outstanding);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rlec_pkg.sv
hdl/rlec_front.sv
hdl/rlec_queue.sv
hdl/rlec_back.sv
hdl/rle_escape_codec.sv
sim/rle_stream_checker.sv
sim/tb.sv
